### hw/rtl/fpsqrt_pkg.sv
package fpsqrt_pkg;

  localparam int unsigned OperandWidth = 32;
  localparam int unsigned RootWidth    = 24;
  localparam int unsigned Q31Width     = 32;

  localparam logic [31:0] Q31ThreeHalves = 32'd3221225472;
  localparam logic [31:0] Q31SqrtTwo     = 32'd3037000500;
  localparam logic [31:0] Q31Max         = 32'd2147483647;

  typedef logic [5:0] exp_t;

  // Default 64-entry reciprocal-root table in Q31.
  localparam logic [31:0] RsqrtDefault [64] = '{
    32'd2147483647, 32'd2130900514, 32'd2114695712, 32'd2098855072,
    32'd2083365155, 32'd2068213207, 32'd2053387115, 32'd2038875363,
    32'd2024666999, 32'd2010751597, 32'd1997119226, 32'd1983760419,
    32'd1970666148, 32'd1957827795, 32'd1945237132, 32'd1932886295,
    32'd1920767766, 32'd1908874353, 32'd1897199171, 32'd1885735627,
    32'd1874477403, 32'd1863418443, 32'd1852552937, 32'd1841875309,
    32'd1831380208, 32'd1821062491, 32'd1810917217, 32'd1800939636,
    32'd1791125178, 32'd1781469446, 32'd1771968208, 32'd1762617387,
    32'd1753413056, 32'd1744351429, 32'd1735428857, 32'd1726641819,
    32'd1717986918, 32'd1709460876, 32'd1701060526, 32'd1692782810,
    32'd1684624773, 32'd1676583558, 32'd1668656405, 32'd1660840641,
    32'd1653133683, 32'd1645533028, 32'd1638036255, 32'd1630641020,
    32'd1623345050, 32'd1616146145, 32'd1609042172, 32'd1602031061,
    32'd1595110808, 32'd1588279467, 32'd1581535150, 32'd1574876026,
    32'd1568300314, 32'd1561806289, 32'd1555392273, 32'd1549056637,
    32'd1542797796, 32'd1536614213, 32'd1530504391, 32'd1524466875
  };

  // Integer square root for elaboration-time table construction.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    rem  = v;
    for (int k = 31; k >= 0; k--) begin
      bitv = 64'd1 << (2 * k);
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // floor(2^62 * n / d) by restoring long division, for n no larger than d.
  function automatic logic [63:0] scaled_ratio(input logic [63:0] n, input logic [63:0] d);
    logic [127:0] num;
    logic [127:0] quo;
    logic [63:0]  rem;
    num = {n, 64'd0} >> 2;
    quo = '0;
    rem = '0;
    for (int k = 127; k >= 0; k--) begin
      rem = {rem[62:0], num[k]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[k] = 1'b1;
      end
    end
    return quo[63:0];
  endfunction

  // Entry i of an n-entry table: floor(2^31 * sqrt(n / (n + i))), saturated.
  function automatic logic [31:0] rsqrt_entry(input int unsigned n, input int unsigned i);
    logic [63:0] d;
    logic [63:0] nn;
    logic [63:0] t;
    logic [63:0] r;
    d   = 64'(n + i);
    nn  = 64'(n);
    if (n == 64) begin
      return RsqrtDefault[i[5:0]];
    end
    t = scaled_ratio(nn, d);
    r = isqrt64(t);
    if (r > {32'd0, Q31Max}) begin
      r = {32'd0, Q31Max};
    end
    return r[31:0];
  endfunction

endpackage

### hw/rtl/fpsqrt_newton.sv
module fpsqrt_newton (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [31:0] y_i,
  input  logic [31:0] m_i,
  input  logic [5:0]  e_i,
  input  logic        zero_i,
  output logic        vld_o,
  output logic [31:0] y_o,
  output logic [31:0] m_o,
  output logic [5:0]  e_o,
  output logic        zero_o
);
  import fpsqrt_pkg::*;

  // Three stages: y*y, times m, then y*(1.5 - e).
  logic        v1_q, v2_q, v3_q;
  logic [31:0] y1_q, m1_q, y2_q, m2_q, ysq_q, err_q, y3_q, m3_q;
  logic [5:0]  e1_q, e2_q, e3_q;
  logic        z1_q, z2_q, z3_q;
  logic [63:0] ysq_full, err_full, y_full;
  logic [31:0] corr;

  assign ysq_full = 64'(y_i) * 64'(y_i);
  assign err_full = 64'(ysq_q) * 64'(m1_q);
  assign corr     = Q31ThreeHalves - err_q;
  assign y_full   = 64'(y2_q) * 64'(corr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ysq_q <= ysq_full[62:31];
      y1_q  <= y_i;
      m1_q  <= m_i;
      e1_q  <= e_i;
      z1_q  <= zero_i;
      err_q <= err_full[63:32];
      y2_q  <= y1_q;
      m2_q  <= m1_q;
      e2_q  <= e1_q;
      z2_q  <= z1_q;
      y3_q  <= y_full[62:31];
      m3_q  <= m2_q;
      e3_q  <= e2_q;
      z3_q  <= z2_q;
    end
  end

  assign vld_o  = v3_q;
  assign y_o    = y3_q;
  assign m_o    = m3_q;
  assign e_o    = e3_q;
  assign zero_o = z3_q;

endmodule

### hw/rtl/fixed_point_square_root.sv
// Fixed-point square root: takes one signed Q16.16 operand per item and
// returns its rounded unsigned Q8.16 root on 24 bits; zero or negative
// operands give 0. The pipeline accepts one item every cycle while the
// output is not stalled. Its stages are normalize, table lookup, two
// three-stage Newton-Raphson refinements, the mantissa multiply, the
// optional sqrt(2) multiply, and the final shift and round.
// Each multiply is followed by a register. A stall at the output freezes
// the whole pipeline; the output register only advances when it is empty
// or being taken, so no item is lost or repeated.
module fixed_point_square_root #(
  parameter int unsigned RSQRT_TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        operand_valid_i,
  output logic        operand_ready_o,
  input  logic [31:0] operand_i,
  output logic        root_valid_o,
  input  logic        root_ready_i,
  output logic [23:0] root_o
);
  import fpsqrt_pkg::*;

  localparam int unsigned IdxW = $clog2(RSQRT_TABLE_ENTRIES);

  logic en;
  logic out_v_q;
  assign en = !out_v_q || root_ready_i;
  assign operand_ready_o = en;

  // Stage 1: leading-zero count, normalization to Q1.31, exponent e = 14 - lz.
  logic [4:0]  lz;
  logic        zero_in;
  always_comb begin
    lz = '0;
    for (int k = 0; k < 31; k++) begin
      if (operand_i[k]) begin
        lz = 5'(30 - k);
      end
    end
  end
  assign zero_in = (operand_i == '0) || operand_i[31];

  logic        s1_v_q, s1_z_q;
  logic [31:0] s1_m_q;
  logic [5:0]  s1_e_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= operand_valid_i && operand_ready_o;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_m_q <= {operand_i[30:0], 1'b0} << lz;
      s1_e_q <= 6'd14 - 6'(lz);
      s1_z_q <= zero_in;
    end
  end

  // Stage 2: table lookup indexed by (m - 1) * N >> 31, which is always below N.
  logic [31+IdxW:0] idx_full;
  logic [IdxW-1:0]  idx;
  logic [31:0]      tbl_y;
  logic [31:0]      rsqrt_rom [RSQRT_TABLE_ENTRIES];
  assign idx_full = (32+IdxW)'({1'b0, s1_m_q[30:0]}) * (32+IdxW)'(RSQRT_TABLE_ENTRIES);
  assign idx      = idx_full[30+IdxW:31];

  for (genvar g = 0; g < RSQRT_TABLE_ENTRIES; g++) begin : g_rom
    localparam logic [31:0] Entry = rsqrt_entry(RSQRT_TABLE_ENTRIES, g);
    assign rsqrt_rom[g] = Entry;
  end
  assign tbl_y = rsqrt_rom[idx];

  logic        s2_v_q, s2_z_q;
  logic [31:0] s2_m_q, s2_y_q;
  logic [5:0]  s2_e_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= s1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_m_q <= s1_m_q;
      s2_y_q <= tbl_y;
      s2_e_q <= s1_e_q;
      s2_z_q <= s1_z_q;
    end
  end

  // Two Newton-Raphson refinements.
  logic        n1_v, n2_v, n1_z, n2_z;
  logic [31:0] n1_y, n1_m, n2_y, n2_m;
  logic [5:0]  n1_e, n2_e;

  fpsqrt_newton u_nr0 (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(s2_v_q), .y_i(s2_y_q), .m_i(s2_m_q), .e_i(s2_e_q), .zero_i(s2_z_q),
    .vld_o(n1_v), .y_o(n1_y), .m_o(n1_m), .e_o(n1_e), .zero_o(n1_z)
  );
  fpsqrt_newton u_nr1 (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(n1_v), .y_i(n1_y), .m_i(n1_m), .e_i(n1_e), .zero_i(n1_z),
    .vld_o(n2_v), .y_o(n2_y), .m_o(n2_m), .e_o(n2_e), .zero_o(n2_z)
  );

  // Root of the mantissa: y * m >> 31.
  logic [63:0] rm_full;
  assign rm_full = 64'(n2_y) * 64'(n2_m);
  logic        s3_v_q, s3_z_q;
  logic [32:0] s3_r_q;
  logic [5:0]  s3_e_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en) s3_v_q <= n2_v;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_r_q <= rm_full[63:31];
      s3_e_q <= n2_e;
      s3_z_q <= n2_z;
    end
  end

  // Odd exponent: times sqrt(2). The root is below 2^32 here.
  logic [64:0] r2_full;
  logic [32:0] r_odd;
  assign r2_full = 65'(s3_r_q) * 65'(Q31SqrtTwo);
  assign r_odd   = s3_e_q[0] ? r2_full[63:31] : s3_r_q;
  logic        s4_v_q, s4_z_q;
  logic [32:0] s4_r_q;
  logic [5:0]  s4_e_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (en) s4_v_q <= s3_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_r_q <= r_odd;
      s4_e_q <= s3_e_q;
      s4_z_q <= s3_z_q;
    end
  end

  // Shift by 14 - floor(e / 2), then round. e is in [-16, 14].
  logic signed [5:0] half;
  logic signed [6:0] sh;
  logic [32:0]       shifted;
  logic [33:0]       rounded;
  assign half    = $signed(s4_e_q) >>> 1;
  assign sh      = 7'sd14 - 7'(half);
  assign shifted = s4_r_q >> sh[5:0];
  assign rounded = 34'(shifted) + 34'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= s4_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) root_o <= s4_z_q ? '0 : rounded[24:1];
  end
  assign root_valid_o = out_v_q;

  ap_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_valid_o && !root_ready_i |=> root_valid_o && $stable(root_o))
    else $error("result changed while stalled");
  ap_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !root_valid_o |-> operand_ready_o)
    else $error("input blocked with empty output");
  ap_neg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q && s4_z_q && en |=> root_o == '0)
    else $error("nonpositive operand gave nonzero root");

endmodule

### tb/fixed_point_square_root_tb.sv
`timescale 1ns / 100ps

// Testbench for the fixed-point square root unit.
// Each operand that the unit accepts is run through a local predictor of the
// normalize, table lookup, two Newton-Raphson refinements, optional sqrt(2)
// multiply and rounding shift. The expected root is queued, and every root
// that the unit hands out is compared with the oldest queued value. Both
// sides idle at random so that stalls land on every stage of the pipeline.
module fixed_point_square_root_tb;
  import fpsqrt_pkg::*;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned Latency      = 11;
  localparam int unsigned WatchdogMax  = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        operand_valid_i;
  logic        operand_ready_o;
  logic [31:0] operand_i;
  logic        root_valid_o;
  logic        root_ready_i;
  logic [23:0] root_o;

  // Expected roots, oldest first.
  logic [23:0] root_queue[$];
  logic [31:0] rsqrt_lut[TableEntries];
  int unsigned mismatch_count;
  int unsigned roots_checked;
  int unsigned operands_sent;
  int unsigned idle_cycles;
  bit          sink_stalls;

  fixed_point_square_root #(
    .RSQRT_TABLE_ENTRIES(TableEntries)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .operand_valid_i(operand_valid_i),
    .operand_ready_o(operand_ready_o),
    .operand_i      (operand_i),
    .root_valid_o   (root_valid_o),
    .root_ready_i   (root_ready_i),
    .root_o         (root_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Reciprocal-root table for 64 entries; entry zero saturates to just below one.
  initial begin
    rsqrt_lut = '{
      32'd2147483647, 32'd2130900514, 32'd2114695712, 32'd2098855072,
      32'd2083365155, 32'd2068213207, 32'd2053387115, 32'd2038875363,
      32'd2024666999, 32'd2010751597, 32'd1997119226, 32'd1983760419,
      32'd1970666148, 32'd1957827795, 32'd1945237132, 32'd1932886295,
      32'd1920767766, 32'd1908874353, 32'd1897199171, 32'd1885735627,
      32'd1874477403, 32'd1863418443, 32'd1852552937, 32'd1841875309,
      32'd1831380208, 32'd1821062491, 32'd1810917217, 32'd1800939636,
      32'd1791125178, 32'd1781469446, 32'd1771968208, 32'd1762617387,
      32'd1753413056, 32'd1744351429, 32'd1735428857, 32'd1726641819,
      32'd1717986918, 32'd1709460876, 32'd1701060526, 32'd1692782810,
      32'd1684624773, 32'd1676583558, 32'd1668656405, 32'd1660840641,
      32'd1653133683, 32'd1645533028, 32'd1638036255, 32'd1630641020,
      32'd1623345050, 32'd1616146145, 32'd1609042172, 32'd1602031061,
      32'd1595110808, 32'd1588279467, 32'd1581535150, 32'd1574876026,
      32'd1568300314, 32'd1561806289, 32'd1555392273, 32'd1549056637,
      32'd1542797796, 32'd1536614213, 32'd1530504391, 32'd1524466875
    };
  end

  // One Newton-Raphson refinement of y ~ 1/sqrt(m), all values in Q31.
  function automatic logic [63:0] refine_rsqrt(input logic [63:0] y, input logic [63:0] m);
    logic [63:0] err;
    logic [63:0] prod;
    prod = y * y;
    err  = ((prod >> 31) * m) >> 32;
    prod = y * (64'(Q31ThreeHalves) - err);
    return prod >> 31;
  endfunction

  // Rounded unsigned Q8.16 square root of a signed Q16.16 operand.
  function automatic logic [23:0] predict_root(input logic [31:0] operand);
    logic [63:0] mant;
    logic [63:0] y;
    logic [63:0] r;
    logic [63:0] idx;
    int          expo;
    int          half;
    int          shamt;
    if (operand == 32'd0 || operand[31]) return 24'd0;
    mant = 64'(operand);
    expo = 15;
    while (mant < 64'h8000_0000) begin
      expo--;
      mant = mant << 1;
    end
    idx = ((mant - 64'h8000_0000) * TableEntries) >> 31;
    if (idx >= TableEntries) idx = TableEntries - 1;
    y = 64'(rsqrt_lut[idx]);
    y = refine_rsqrt(y, mant);
    y = refine_rsqrt(y, mant);
    r = (y * mant) >> 31;
    // An odd exponent leaves a factor of sqrt(2) for the root to absorb.
    if (expo % 2 != 0) r = (r * 64'(Q31SqrtTwo)) >> 31;
    // Floor halving keeps operands below one from wrapping the shift.
    half  = (expo >= 0) ? (expo / 2) : -((1 - expo) / 2);
    shamt = 14 - half;
    if (shamt < 0) shamt = 0;
    if (shamt > 63) shamt = 63;
    r = (r >> shamt) + 64'd1;
    return r[24:1];
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // Send one operand; valid holds with a stable payload until accepted.
  // Valid stays high after acceptance so that a following item can go out
  // in the next cycle; a gap or a drain drops it.
  task automatic send_operand(input logic [31:0] value, input bit with_gaps);
    int unsigned gap;
    gap = with_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      operand_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    operand_valid_i <= 1'b1;
    operand_i       <= value;
    @(posedge clk_i);
    while (!operand_ready_o) @(posedge clk_i);
    root_queue.push_back(predict_root(value));
    operands_sent++;
  endtask

  task automatic wait_drained();
    operand_valid_i <= 1'b0;
    while (root_queue.size() != 0) @(posedge clk_i);
  endtask

  // Extremes of the field, the rounding boundaries and operands below one.
  task automatic test_directed();
    logic [31:0] picks[$];
    picks = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
              32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0001_0000,
              32'h0000_8000, 32'h0000_4000, 32'h0002_0000, 32'h0004_0000,
              32'h0001_FFFF, 32'h0001_0400, 32'h4000_0000, 32'h4000_0001,
              32'h7FFF_0000, 32'h0003_0000, 32'h0000_00FF, 32'hAAAA_AAAA,
              32'h5555_5555, 32'h00FF_FFFF, 32'h0001_8000};
    foreach (picks[k]) send_operand(picks[k], 1'b0);
  endtask

  // Random operands of every magnitude.
  task automatic test_random(input int unsigned count);
    logic [31:0] value;
    int unsigned lead;
    repeat (count) begin
      case ($urandom_range(0, 5))
        0: value = $urandom();
        1: value = $urandom_range(1, 255);
        2: value = {1'b1, 31'($urandom())};
        default: begin
          lead  = $urandom_range(0, 30);
          value = ($urandom() & ((32'd1 << lead) - 1)) | (32'd1 << lead);
        end
      endcase
      send_operand(value, 1'b1);
    end
  endtask

  // Back-to-back burst after waiting for every outstanding root.
  task automatic test_burst_after_drain();
    wait_drained();
    sink_stalls = 1'b0;
    repeat (40) send_operand($urandom() & 32'h7FFF_FFFF, 1'b0);
    wait_drained();
    sink_stalls = 1'b1;
  endtask

  // Result side: random stalls, one check per accepted root.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_ready_i <= 1'b0;
    end else begin
      if (root_valid_o && root_ready_i) begin
        roots_checked++;
        if (root_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected root %0d", root_o);
        end else begin
          if (root_o !== root_queue[0]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("root mismatch: expected %0d, got %0d", root_queue[0], root_o);
          end
          void'(root_queue.pop_front());
        end
      end
      if (!sink_stalls) root_ready_i <= 1'b1;
      else if ($urandom_range(0, 29) == 0) root_ready_i <= 1'b0;
      else root_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog: counts cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if ((operand_valid_i && operand_ready_o) || (root_valid_o && root_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogMax) begin
      $display("Timeout with %0d roots outstanding", root_queue.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    operand_valid_i = 1'b0;
    operand_i       = '0;
    mismatch_count  = 0;
    roots_checked   = 0;
    operands_sent   = 0;
    idle_cycles     = 0;
    sink_stalls     = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_burst_after_drain();
    test_random(340);

    wait_drained();
    repeat (Latency + 5) @(posedge clk_i);
    $display("Sent %0d operands and checked %0d roots, including signed extremes,",
             operands_sent, roots_checked);
    $display("operands below one, every leading-one position and output stalls.");
    if (mismatch_count == 0 && root_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### fixed_point_square_root.f
hw/rtl/fpsqrt_pkg.sv
hw/rtl/fpsqrt_newton.sv
hw/rtl/fixed_point_square_root.sv
tb/fixed_point_square_root_tb.sv
